// ===== hdl/hed_pkg.sv =====
// ----------------------------------------------------------------------------
// HTML entity decoder package
// Shared widths, character codes, the entity table and the decision record
// passed from the head matcher to the control logic.
// ----------------------------------------------------------------------------
package hed_pkg;

   // Look-ahead window geometry.
   localparam int WIN_DEPTH = 6;
   localparam int FILL_W    = 3;
   localparam int KEY_COUNT = 5;
   localparam int NAME_MAX  = 4;

   // Character codes.
   localparam logic [7:0] CHAR_AMP   = 8'h26;
   localparam logic [7:0] CHAR_SEMI  = 8'h3B;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CASE_DELTA = 8'h20;

   // Entity names in lower case, their letter counts and decoded values.
   // Order matters: the first entry that matches wins.
   localparam logic [7:0] KEY_NAME [KEY_COUNT][NAME_MAX] = '{
      '{8'h6C, 8'h74, 8'h00, 8'h00},   // lt
      '{8'h67, 8'h74, 8'h00, 8'h00},   // gt
      '{8'h61, 8'h6D, 8'h70, 8'h00},   // amp
      '{8'h61, 8'h70, 8'h6F, 8'h73},   // apos
      '{8'h71, 8'h75, 8'h6F, 8'h74}    // quot
   };
   localparam logic [FILL_W-1:0] KEY_LEN [KEY_COUNT] = '{3'd2, 3'd2, 3'd3, 3'd4, 3'd4};
   localparam logic [7:0] KEY_VALUE [KEY_COUNT] = '{8'h3C, 8'h3E, 8'h26, 8'h27, 8'h22};

   // Window contents, head in element 0.
   typedef logic [WIN_DEPTH-1:0][7:0] window_type;

   // Outcome of one decision at the window head.
   typedef struct packed {
      logic [7:0]        out_byte;
      logic [FILL_W-1:0] skip;
   } decision_type;

endpackage

// ===== hdl/hed_cell.sv =====
// ----------------------------------------------------------------------------
// HTML entity decoder window cell
// One byte of the look-ahead window. On a shift it takes the byte of its
// neighbor toward the tail; a load puts a new request byte in place.
// ----------------------------------------------------------------------------
module hed_cell (
   input  logic       clock,
   input  logic       shift,
   input  logic       load,
   input  logic [7:0] nbr_byte,
   input  logic [7:0] new_byte,
   output logic [7:0] cell_byte
);

   logic [7:0] byte_ff;
   logic [7:0] byte_in;

   // A load wins over the shift, since it targets the first free place.
   always_comb begin
      if (load) begin
         byte_in = new_byte;
      end else if (shift) begin
         byte_in = nbr_byte;
      end else begin
         byte_in = byte_ff;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
   end

   assign cell_byte = byte_ff;

endmodule

// ===== hdl/hed_matcher.sv =====
// ----------------------------------------------------------------------------
// HTML entity decoder head matcher
// Looks at the window head and decides which byte it stands for, and how
// many following bytes an entity (and its optional semicolon) consumes.
// ----------------------------------------------------------------------------
module hed_matcher (
   input  hed_pkg::window_type            window,
   input  logic [hed_pkg::FILL_W-1:0]     fill,
   output hed_pkg::decision_type          decision
);
   import hed_pkg::*;

   logic              found;
   logic              lower_ok;
   logic              upper_ok;
   logic [FILL_W-1:0] span;
   logic [FILL_W-1:0] extra;

   // Try every entity in table order; only bytes present in the window count.
   always_comb begin
      found             = 1'b0;
      lower_ok          = 1'b1;
      upper_ok          = 1'b1;
      span              = '0;
      extra             = '0;
      decision.out_byte = window[0];
      decision.skip     = '0;
      if (window[0] == CHAR_AMP) begin
         for (int k = 0; k < KEY_COUNT; k++) begin
            span     = KEY_LEN[k] + 3'd1;
            lower_ok = 1'b1;
            upper_ok = 1'b1;
            for (int i = 0; i < NAME_MAX; i++) begin
               if (3'(i) < KEY_LEN[k]) begin
                  if (window[i + 1] != KEY_NAME[k][i]) begin
                     lower_ok = 1'b0;
                  end
                  if (window[i + 1] != (KEY_NAME[k][i] - CASE_DELTA)) begin
                     upper_ok = 1'b0;
                  end
               end
            end
            // A semicolon is taken only when it is already in the window.
            extra = ((span < fill) && (window[span] == CHAR_SEMI)) ? 3'd1 : 3'd0;
            if (!found && (span <= fill) && (lower_ok || upper_ok)) begin
               found             = 1'b1;
               decision.out_byte = KEY_VALUE[k];
               decision.skip     = KEY_LEN[k] + extra;
            end
         end
      end
   end

endmodule

// ===== hdl/html_entity_decoder.sv =====
// ----------------------------------------------------------------------------
// HTML entity decoder
// Streams text one byte per request, turns + into a space and replaces the
// entities lt, gt, amp, apos and quot (all lower or all upper case) by their characters.
// ----------------------------------------------------------------------------
// Throughput: one request per cycle while the six-cell window runs full and no
// result is stalled; a decision at the window head pops one cell each cycle.
// A result is registered from the head decision once the request that fills
// the window to six bytes sits in its cell.
// A last request starts a flush of one decision per cycle unless a result is
// stalled, until the window is empty and the flush ends, with req_tready low meanwhile.
// Reset empties the window, clears the skip count and the flush flag and drops rsp_tvalid.
module html_entity_decoder (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_byte
   input  logic       req_tlast,   // in_final
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic       rsp_tlast    // out_final
);
   import hed_pkg::*;

   localparam logic [FILL_W-1:0] FULL = FILL_W'(WIN_DEPTH);

   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [FILL_W-1:0] skip_ff, skip_in;
   logic              flushing_ff, flushing_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [7:0]        rsp_byte_ff, rsp_byte_in;
   logic              rsp_last_ff, rsp_last_in;

   logic              pop_cond;
   logic              out_free;
   logic              pop;
   logic              emit;
   logic              load;
   logic [FILL_W-1:0] load_idx;
   logic [7:0]        new_byte;
   window_type        window;
   decision_type      decision;

   // Pop control: steady decisions need a full window, the flush drains it.
   assign pop_cond   = flushing_ff ? (fill_ff != '0) : (fill_ff == FULL);
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign pop        = pop_cond && ((skip_ff != '0) || out_free);
   assign emit       = pop && (skip_ff == '0);
   assign req_tready = !flushing_ff && ((fill_ff != FULL) || pop);
   assign load       = req_tvalid && req_tready;
   assign load_idx   = pop ? (fill_ff - 3'd1) : fill_ff;
   assign new_byte   = (req_tdata == CHAR_PLUS) ? CHAR_SPACE : req_tdata;

   // The window as a row of cells, head in cell 0.
   for (genvar i = 0; i < WIN_DEPTH; i++) begin : g_cell
      logic [7:0] nbr;
      if (i == WIN_DEPTH - 1) begin : g_tail
         assign nbr = '0;
      end else begin : g_body
         assign nbr = window[i + 1];
      end
      hed_cell u_cell (
         .clock     (clock),
         .shift     (pop),
         .load      (load && (load_idx == FILL_W'(i))),
         .nbr_byte  (nbr),
         .new_byte  (new_byte),
         .cell_byte (window[i])
      );
   end

   hed_matcher u_matcher (
      .window   (window),
      .fill     (fill_ff),
      .decision (decision)
   );

   // Next values of fill, skip count, flush flag and the result register.
   always_comb begin
      fill_in      = fill_ff - {2'b00, pop} + {2'b00, load};
      skip_in      = skip_ff;
      flushing_in  = flushing_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      if (pop) begin
         skip_in = (skip_ff != '0) ? (skip_ff - 3'd1) : decision.skip;
      end
      if (load && req_tlast) begin
         flushing_in = 1'b1;
      end else if (flushing_ff && (fill_ff == '0)) begin
         flushing_in = 1'b0;
      end
      // During a flush a byte is the last when only skipped bytes follow it.
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_byte_in  = decision.out_byte;
         rsp_last_in  = flushing_ff && ((fill_ff - 3'd1) == decision.skip);
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         skip_ff      <= '0;
         flushing_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fill_ff      <= fill_in;
         skip_ff      <= skip_in;
         flushing_ff  <= flushing_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_byte_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ===== hdl/hed_checker.sv =====
// ----------------------------------------------------------------------------
// HTML entity decoder checker
// Port-level assertions on the decoder, bound to its top level.
// ----------------------------------------------------------------------------
module hed_assert_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic       req_tlast,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tlast
);

   // A stalled result holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result changed while stalled");

   // Reset leaves no result pending.
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // The last request of a text starts the flush, which takes no request.
   a_flush_blocks: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tlast |=> !req_tready)
      else $error("request taken right after the last request of a text");

   // A stalled result is not lost when a request is taken meanwhile.
   a_rsp_no_overrun: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready && req_tvalid && req_tready |=> rsp_tvalid)
      else $error("pending result lost");

endmodule

bind html_entity_decoder hed_assert_checker u_hed_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
